@@ rtl/srss_pkg.sv @@
package srss_pkg;

  localparam int MAX_RELAYS = 8;
  localparam int IDX_W      = $clog2(MAX_RELAYS);
  localparam int CNT_W      = $clog2(MAX_RELAYS + 1);

  localparam logic [CNT_W-1:0] RELAY_COUNT_RST = CNT_W'(MAX_RELAYS);
  localparam logic [15:0]      HOLD_RST        = 16'd300;
  localparam logic [15:0]      PERIOD_RST      = 16'd75;

  // request codes
  localparam logic [1:0] REQ_SET   = 2'd0;
  localparam logic [1:0] REQ_TOGG  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;
  localparam logic [1:0] REQ_QUERY = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_ACK    = 2'd0;
  localparam logic [1:0] KIND_REPORT = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_RELAY_COUNT  = 3'd0;
  localparam logic [2:0] CFG_INVERT_MASK  = 3'd1;
  localparam logic [2:0] CFG_INITIAL_MASK = 3'd2;
  localparam logic [2:0] CFG_HOLD_TIME    = 3'd3;
  localparam logic [2:0] CFG_CHECK_PERIOD = 3'd4;
  localparam logic [2:0] CFG_REPORT_EN    = 3'd5;

endpackage

@@ rtl/staggered_relay_switch_sequencer.sv @@
// Path: a set, toggle or query goes through ST_ACK, and a tick without a scan pass through
// ST_TICK, to the output register; a tick with a pass goes through ST_TICK, a read and a check
// per relay up to the first switch, reports when enabled, then ST_SUMMARY; stalls hold it.
// Throughput: one item at a time; the next input is taken once the last result is loaded.
// Reset (rst, synchronous): registers at defaults, switch times read as zero through
// per-entry valid bits, nothing reported yet, no clearing pass; no transfer during reset.
module staggered_relay_switch_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // relay_index[2:0], set_value[3], link_up[4], zero[7:5]
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // relay_index_res[2:0], state_bit[3], found[4], switched[5],
                                 // drive_levels[13:6], zero[15:14]
  output logic [1:0]  m_tuser,   // kind[1:0]
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int N  = srss_pkg::MAX_RELAYS;
  localparam int IW = srss_pkg::IDX_W;
  localparam int CW = srss_pkg::CNT_W;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_ACK     = 3'd1;
  localparam logic [2:0] ST_TICK    = 3'd2;
  localparam logic [2:0] ST_SCAN_RD = 3'd3;
  localparam logic [2:0] ST_SCAN_CK = 3'd4;
  localparam logic [2:0] ST_REPORT  = 3'd5;
  localparam logic [2:0] ST_SUMMARY = 3'd6;

  logic [2:0]    state, state_next;

  logic [3:0]    relay_count;
  logic [N-1:0]  invert_mask;
  logic [15:0]   hold_time_ms;
  logic [15:0]   check_period_ms;
  logic          report_enable;

  logic [31:0]   time_now, last_check_time;
  logic [N-1:0]  desired_state, drive_level, reported_valid, reported_value;

  logic [1:0]    req_q;
  logic [IW-1:0] idx_q;
  logic          setv_q, link_q;

  logic [CW-1:0] scan_idx;
  logic          sw;
  logic [IW-1:0] swidx;
  logic          swst;

  // switch time store, one entry per relay
  logic [31:0]   st_mem [N];
  logic [N-1:0]  st_valid;
  logic [31:0]   rd_data;
  logic          rd_vld;
  logic          st_we;

  logic          out_valid;
  logic [1:0]    out_kind;
  logic [IW-1:0] out_idx;
  logic          out_st, out_fnd, out_sw, out_last;
  logic [N-1:0]  out_drive;

  logic          out_free, out_load;
  logic [1:0]    em_kind;
  logic [IW-1:0] em_idx;
  logic          em_st, em_fnd, em_sw, em_last;

  logic [CW-1:0] cnt;
  logic          in_fire, cfg_fire;
  logic [N-1:0]  ack_desired;
  logic          ack_fnd;
  logic [31:0]   eff_time, elapsed;
  logic          do_switch, rep_need;
  logic [IW-1:0] sidx;

  assign cnt = (relay_count > 4'(N)) ? CW'(N) : CW'(relay_count);
  assign sidx = scan_idx[IW-1:0];

  assign s_tready  = (state == ST_IDLE) && !rst;
  assign in_fire   = s_tvalid && s_tready;
  assign cfg_ready = !rst;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_free  = !out_valid || m_tready;

  assign ack_fnd = {1'b0, idx_q} < cnt;
  always_comb begin
    ack_desired = desired_state;
    case (req_q)
      srss_pkg::REQ_SET:  ack_desired[idx_q] = setv_q;
      srss_pkg::REQ_TOGG: ack_desired[idx_q] = !desired_state[idx_q];
      default:            ack_desired = desired_state;
    endcase
  end

  assign eff_time  = rd_vld ? rd_data : 32'd0;
  assign elapsed   = time_now - eff_time;
  assign do_switch = (elapsed > {16'd0, hold_time_ms}) &&
                     ((drive_level[sidx] ^ invert_mask[sidx]) != desired_state[sidx]);
  assign rep_need  = !reported_valid[sidx] || (reported_value[sidx] != desired_state[sidx]);
  assign st_we     = (state == ST_SCAN_CK) && do_switch;

  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    em_kind    = srss_pkg::KIND_ACK;
    em_idx     = '0;
    em_st      = 1'b0;
    em_fnd     = 1'b0;
    em_sw      = 1'b0;
    em_last    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = (s_tuser == srss_pkg::REQ_TICK) ? ST_TICK : ST_ACK;
        end
      end
      ST_ACK: begin
        em_kind = srss_pkg::KIND_ACK;
        em_idx  = idx_q;
        em_st   = ack_fnd && ack_desired[idx_q];
        em_fnd  = ack_fnd;
        em_last = 1'b1;
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_TICK: begin
        if ((time_now - last_check_time) < {16'd0, check_period_ms}) begin
          em_kind = srss_pkg::KIND_TICK;
          em_last = 1'b1;
          if (out_free) begin
            out_load   = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        if (scan_idx >= cnt) begin
          state_next = (report_enable && link_q) ? ST_REPORT : ST_SUMMARY;
        end else begin
          state_next = ST_SCAN_CK;
        end
      end
      ST_SCAN_CK: begin
        if (do_switch) begin
          state_next = (report_enable && link_q) ? ST_REPORT : ST_SUMMARY;
        end else begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_REPORT: begin
        em_kind = srss_pkg::KIND_REPORT;
        em_idx  = sidx;
        em_st   = desired_state[sidx];
        if (scan_idx >= cnt) begin
          state_next = ST_SUMMARY;
        end else if (rep_need) begin
          out_load = out_free;
        end
      end
      ST_SUMMARY: begin
        em_kind = srss_pkg::KIND_TICK;
        em_idx  = swidx;
        em_st   = swst;
        em_sw   = sw;
        em_last = 1'b1;
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[sidx] <= time_now;
    end
    if (state == ST_SCAN_RD) begin
      rd_data <= st_mem[sidx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      relay_count     <= 4'(srss_pkg::RELAY_COUNT_RST);
      invert_mask     <= '0;
      hold_time_ms    <= srss_pkg::HOLD_RST;
      check_period_ms <= srss_pkg::PERIOD_RST;
      report_enable   <= 1'b1;
      time_now        <= '0;
      last_check_time <= '0;
      desired_state   <= '0;
      drive_level     <= '0;
      reported_valid  <= '0;
      reported_value  <= '0;
      st_valid        <= '0;
      rd_vld          <= 1'b0;
      scan_idx        <= '0;
      sw              <= 1'b0;
      swidx           <= '0;
      swst            <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_fire) begin
        case (cfg_index)
          srss_pkg::CFG_RELAY_COUNT:  relay_count <= cfg_data[3:0];
          srss_pkg::CFG_INVERT_MASK:  invert_mask <= cfg_data[N-1:0];
          srss_pkg::CFG_INITIAL_MASK: begin
            desired_state <= cfg_data[N-1:0];
            drive_level   <= cfg_data[N-1:0] ^ invert_mask;
          end
          srss_pkg::CFG_HOLD_TIME:    hold_time_ms    <= cfg_data;
          srss_pkg::CFG_CHECK_PERIOD: check_period_ms <= cfg_data;
          srss_pkg::CFG_REPORT_EN:    report_enable   <= cfg_data[0];
          default: ;
        endcase
      end

      if (in_fire && (s_tuser == srss_pkg::REQ_TICK)) begin
        time_now <= time_now + 32'd1;
      end

      if ((state == ST_ACK) && out_free && ack_fnd) begin
        desired_state <= ack_desired;
      end

      // start a pass: clear the switch summary and rewind the scan
      if ((state == ST_TICK) && (state_next == ST_SCAN_RD)) begin
        last_check_time <= time_now;
        scan_idx        <= '0;
        sw              <= 1'b0;
        swidx           <= '0;
        swst            <= 1'b0;
      end

      if (state == ST_SCAN_RD) begin
        rd_vld <= st_valid[sidx];
        if (scan_idx >= cnt) begin
          scan_idx <= '0;
        end
      end

      if (state == ST_SCAN_CK) begin
        if (do_switch) begin
          drive_level[sidx] <= desired_state[sidx] ^ invert_mask[sidx];
          st_valid[sidx]    <= 1'b1;
          sw                <= 1'b1;
          swidx             <= sidx;
          swst              <= desired_state[sidx];
          scan_idx          <= '0;
        end else begin
          scan_idx <= scan_idx + CW'(1);
        end
      end

      if ((state == ST_REPORT) && (scan_idx < cnt)) begin
        if (!rep_need || out_free) begin
          scan_idx <= scan_idx + CW'(1);
        end
        if (rep_need && out_free) begin
          reported_valid[sidx] <= 1'b1;
          reported_value[sidx] <= desired_state[sidx];
        end
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // hold the link flag and the request fields for the item at work, and the result fields on a load
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_q  <= s_tuser;
      idx_q  <= s_tdata[IW-1:0];
      setv_q <= s_tdata[3];
      link_q <= s_tdata[4];
    end
    if (out_load) begin
      out_kind  <= em_kind;
      out_idx   <= em_idx;
      out_st    <= em_st;
      out_fnd   <= em_fnd;
      out_sw    <= em_sw;
      out_last  <= em_last;
      out_drive <= drive_level;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;
  assign m_tdata  = {2'b00, out_drive, out_sw, out_fnd, out_st, out_idx};

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free)
    else $error("result loaded over a waiting transfer");

  a_one_switch: assert property (@(posedge clk) disable iff (rst)
    st_we |-> !sw)
    else $error("second relay switched in one pass");

  a_sum_level: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SUMMARY) && sw |-> drive_level[swidx] == (swst ^ invert_mask[swidx]))
    else $error("switched relay level disagrees with summary");

  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state != ST_IDLE)
    else $error("accepted item dropped");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN_CK) |-> scan_idx < cnt)
    else $error("scan beyond relay count");

endmodule
